### hdl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int WORD_W   = 32;
  localparam int MODE_W   = 3;
  localparam int NUMBER_W = 31;
  localparam int DEPTH_W  = 7;
  localparam int STATUS_W = 3;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;

  localparam logic [MODE_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] OP_ADD   = 3'd1;
  localparam logic [MODE_W-1:0] OP_SUB   = 3'd2;
  localparam logic [MODE_W-1:0] OP_MUL   = 3'd3;
  localparam logic [MODE_W-1:0] OP_DIV   = 3'd4;
  localparam logic [MODE_W-1:0] OP_POW   = 3'd5;
  localparam logic [MODE_W-1:0] OP_CLEAR = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERONEG   = 3'd4;

  typedef struct packed {
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   result;
  } alu_resp_t;

endpackage
`default_nettype wire

### hdl/rpn_ram.sv
`default_nettype none
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/rpn_alu.sv
`default_nettype none
module rpn_alu import rpn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MODE_W-1:0] op,
  input  wire logic [WORD_W-1:0] lhs,
  input  wire logic [WORD_W-1:0] rhs,
  output alu_resp_t              resp
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_DIV  = 3'd2;
  localparam logic [2:0] A_DIVF = 3'd3;
  localparam logic [2:0] A_POWM = 3'd4;
  localparam logic [2:0] A_POWS = 3'd5;

  logic [2:0]          state;
  logic [WORD_W-1:0]   acc;
  logic [WORD_W-1:0]   base;
  logic [WORD_W-2:0]   ex;
  logic [WORD_W-1:0]   rem;
  logic [WORD_W-1:0]   quo;
  logic [WORD_W-1:0]   md;
  logic                neg;
  logic [4:0]          cnt;

  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_p;
  logic [WORD_W:0]     shifted;
  logic [WORD_W:0]     trial;
  logic                fits;

  // one multiplier serves plain multiply, accumulate and squaring
  assign mul_a   = (state == A_POWS) ? base : acc;
  assign mul_p   = mul_a * base;
  assign shifted = {rem, quo[WORD_W-1]};
  assign trial   = shifted - {1'b0, md};
  assign fits    = !trial[WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= A_IDLE;
      resp.done <= 1'b0;
    end else begin
      case (state)
        A_IDLE: begin
          if (start) begin
            case (op)
              OP_ADD: begin
                resp.result <= lhs + rhs;
                resp.status <= ST_OK;
                resp.done   <= 1'b1;
              end
              OP_SUB: begin
                resp.result <= lhs - rhs;
                resp.status <= ST_OK;
                resp.done   <= 1'b1;
              end
              OP_MUL: begin
                acc       <= lhs;
                base      <= rhs;
                state     <= A_MUL;
                resp.done <= 1'b0;
              end
              OP_DIV: begin
                if (rhs == '0) begin
                  resp.result <= '0;
                  resp.status <= ST_DIVZERO;
                  resp.done   <= 1'b1;
                end else begin
                  rem       <= '0;
                  quo       <= lhs[WORD_W-1] ? -lhs : lhs;
                  md        <= rhs[WORD_W-1] ? -rhs : rhs;
                  neg       <= lhs[WORD_W-1] ^ rhs[WORD_W-1];
                  cnt       <= '0;
                  state     <= A_DIV;
                  resp.done <= 1'b0;
                end
              end
              OP_POW: begin
                if (!rhs[WORD_W-1]) begin
                  acc       <= 32'd1;
                  base      <= lhs;
                  ex        <= rhs[WORD_W-2:0];
                  state     <= A_POWM;
                  resp.done <= 1'b0;
                end else begin
                  // negative exponent: only bases zero, one and minus one matter
                  resp.done <= 1'b1;
                  if (lhs == '0) begin
                    resp.result <= '0;
                    resp.status <= ST_ZERONEG;
                  end else if (lhs == 32'd1) begin
                    resp.result <= 32'd1;
                    resp.status <= ST_OK;
                  end else if (lhs == '1) begin
                    resp.result <= rhs[0] ? '1 : 32'd1;
                    resp.status <= ST_OK;
                  end else begin
                    resp.result <= '0;
                    resp.status <= ST_OK;
                  end
                end
              end
              default: begin
                resp.result <= '0;
                resp.status <= ST_OK;
                resp.done   <= 1'b1;
              end
            endcase
          end else begin
            resp.done <= 1'b0;
          end
        end
        A_MUL: begin
          resp.result <= mul_p;
          resp.status <= ST_OK;
          resp.done   <= 1'b1;
          state       <= A_IDLE;
        end
        A_DIV: begin
          rem       <= fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
          quo       <= {quo[WORD_W-2:0], fits};
          cnt       <= cnt + 5'd1;
          resp.done <= 1'b0;
          if (cnt == 5'd31) begin
            state <= A_DIVF;
          end
        end
        A_DIVF: begin
          resp.result <= neg ? -quo : quo;
          resp.status <= ST_OK;
          resp.done   <= 1'b1;
          state       <= A_IDLE;
        end
        A_POWM: begin
          if (ex == '0) begin
            resp.result <= acc;
            resp.status <= ST_OK;
            resp.done   <= 1'b1;
            state       <= A_IDLE;
          end else begin
            if (ex[0]) begin
              acc <= mul_p;
            end
            resp.done <= 1'b0;
            state     <= A_POWS;
          end
        end
        A_POWS: begin
          base      <= mul_p;
          ex        <= ex >> 1;
          resp.done <= 1'b0;
          state     <= A_POWM;
        end
        default: begin
          resp.done <= 1'b0;
          state     <= A_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/rpn_stack_evaluator_core.sv
// channel  dir  fields in tdata / tuser, lowest bit first
// -------  ---  ----------------------------------------------------------
// s_*      in   tdata: mode[2:0], number[33:3], zero pad [39:34]
// m_*      out  tdata: top_value[31:0], depth[38:32], status[41:39], pad
//
// Push, clear and underflow/full tokens go straight to the output. Divide makes
// one quotient bit a cycle in the shared unit, or ends at start for a zero divisor;
// power does a multiply and a square step per exponent bit up to its highest set
// bit. The stack sits in a single-port-write RAM with registered read, so each
// operator fetches its left operand in a read state first; the top is kept in a
// register. Synchronous reset empties the stack; RAM contents are not cleared.
// s_tready is low while a token is in work; a stalled result holds m_tdata
// and the next token is still taken while it waits.
`default_nettype none
module rpn_stack_evaluator_core import rpn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // mode[2:0], number[33:3]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata    // top_value[31:0], depth[38:32], status[41:39]
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

  logic [1:0]          state;
  logic [SP_W-1:0]     sp;
  logic [WORD_W-1:0]   top;
  logic [MODE_W-1:0]   op;
  logic [STATUS_W-1:0] stat;

  logic                accept;
  logic [MODE_W-1:0]   in_mode;
  logic [NUMBER_W-1:0] in_num;
  logic [SP_W-1:0]     below;
  logic                push_ok;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [WORD_W-1:0]   wdata;
  logic [WORD_W-1:0]   rd_data;
  alu_resp_t           resp;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_num   = s_tdata[MODE_W+NUMBER_W-1:MODE_W];
  assign below    = sp - SP_W'(2);
  assign push_ok  = (in_mode == OP_PUSH) && (sp != SP_FULL);

  assign we    = (accept && push_ok) ||
                 (state == S_EXEC && resp.done && resp.status == ST_OK);
  assign waddr = (state == S_IDLE) ? sp[ADDR_W-1:0] : below[ADDR_W-1:0];
  assign wdata = (state == S_IDLE) ? {1'b0, in_num} : resp.result;

  rpn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (below[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_READ),
    .op    (op),
    .lhs   (rd_data),
    .rhs   (top),
    .resp  (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sp       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // load a fresh result, or drop the one just taken
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= in_mode;
            case (in_mode)
              OP_PUSH: begin
                state <= S_OUT;
                if (push_ok) begin
                  top  <= {1'b0, in_num};
                  sp   <= sp + SP_W'(1);
                  stat <= ST_OK;
                end else begin
                  stat <= ST_FULL;
                end
              end
              OP_CLEAR: begin
                sp    <= '0;
                stat  <= ST_OK;
                state <= S_OUT;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
                if (sp < SP_W'(2)) begin
                  stat  <= ST_UNDERFLOW;
                  state <= S_OUT;
                end else begin
                  stat  <= ST_OK;
                  state <= S_READ;
                end
              end
              default: begin
                // unused mode: report only
                stat  <= ST_OK;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (resp.done) begin
            stat  <= resp.status;
            state <= S_OUT;
            if (resp.status == ST_OK) begin
              top <= resp.result;
              sp  <= sp - SP_W'(1);
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {6'd0, stat, DEPTH_W'(sp), (sp == '0) ? WORD_W'(0) : top};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/rpn_checker.sv
`default_nettype none
module rpn_checker import rpn_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  logic [DEPTH_W-1:0]  out_depth;
  logic [STATUS_W-1:0] out_status;

  assign out_depth  = m_tdata[WORD_W+DEPTH_W-1:WORD_W];
  assign out_status = m_tdata[WORD_W+DEPTH_W+STATUS_W-1:WORD_W+DEPTH_W];

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one token at a time: ready drops after each accepted item
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a token is in work");

  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status == ST_FULL |-> out_depth == DEPTH_W'(STACK_DEPTH))
    else $error("full status with stack not full");

  a_underflow_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status == ST_UNDERFLOW |-> out_depth < DEPTH_W'(2))
    else $error("underflow status with two or more entries");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_depth == '0 && out_status != ST_FULL
      |-> m_tdata[WORD_W-1:0] == '0 || STACK_DEPTH >= 128)
    else $error("empty stack reports nonzero top");

endmodule

bind rpn_stack_evaluator_core rpn_checker u_checker (.*);
`default_nettype wire
